[sv/tint_pkg.sv]
// Shared types and constants for the table interpolator.
// No dependencies; imported by tint_muldiv and table_interpolator.
package tint_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = 6;
  localparam int MAG_W       = VALUE_WIDTH + 1;
  localparam int STEP_W      = $clog2(MAG_W);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [MAG_W-1:0]              mag_t;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_INV   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_ZERO_SEG = 2'd3;

endpackage

[sv/table_interpolator.sv]
// Piecewise-linear table interpolator: point store, segment search and serial mul/div.
// Depends on tint_pkg and tint_muldiv. One item is worked on at a time.
// Writes, unused modes and lookups in tables of fewer than two points go straight from
// idle to the done state. A lookup searches the segments in order and, on a hit in a
// segment that is not flat, runs the multiplier and divider. A new item is taken only
// once the last result has moved to the output register. Reset clears control and point_count, not the table.
module table_interpolator import tint_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_mode,
  input  logic [IDX_W-1:0]       in_point_index,
  input  value_t                 in_abscissa,
  input  value_t                 in_ordinate,
  input  value_t                 in_query,
  output logic                   out_valid,
  input  logic                   out_ready,
  output value_t                 out_answer,
  output logic [1:0]             out_status,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_SCAN, S_PREP, S_CALC, S_DONE} state_t;

  typedef struct packed {
    value_t x;
    value_t y;
  } point_t;

  point_t             mem [MAX_POINTS];
  point_t             rd_data_r;
  logic [IDX_W-1:0]   rd_addr;

  state_t             state_r;
  logic [CNT_W-1:0]   point_count_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   last_r;
  logic [1:0]         mode_r;
  value_t             query_r;
  point_t             prev_r;
  point_t             cur_r;
  logic               neg_r;
  value_t             res_answer_r;
  logic [1:0]         res_status_r;
  logic               out_valid_r;
  value_t             out_answer_r;
  logic [1:0]         out_status_r;

  logic               in_fire;
  logic               out_load;
  logic               cfg_write;
  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   count_less;

  value_t             s_prev, s_cur, t_prev, t_cur;
  value_t             seg_lo, seg_hi;
  logic               seg_hit;
  logic               seg_flat;

  logic signed [VALUE_WIDTH:0] d_this, d_other, d_off;
  mag_t               mag_this, mag_other, mag_off;
  logic               md_done;
  mag_t               md_quo;
  logic [VALUE_WIDTH+1:0] ans_wide;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, point_count_r} : 32'd0;

  assign count_eff  = (point_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : point_count_r;
  assign count_less = count_eff - 1'b1;

  always_comb begin
    unique case (state_r)
      S_FIRST: rd_addr = IDX_W'(1);
      S_SCAN:  rd_addr = idx_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_mode == MODE_WRITE) begin
      mem[in_point_index] <= '{x: in_abscissa, y: in_ordinate};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    s_prev   = (mode_r == MODE_INV) ? prev_r.y : prev_r.x;
    t_prev   = (mode_r == MODE_INV) ? prev_r.x : prev_r.y;
    s_cur    = (mode_r == MODE_INV) ? rd_data_r.y : rd_data_r.x;
    seg_lo   = (s_prev < s_cur) ? s_prev : s_cur;
    seg_hi   = (s_prev < s_cur) ? s_cur : s_prev;
    seg_hit  = (seg_lo <= query_r) && (query_r <= seg_hi);
    seg_flat = (seg_lo == seg_hi);
  end

  always_comb begin
    t_cur     = (mode_r == MODE_INV) ? cur_r.x : cur_r.y;
    d_this    = {((mode_r == MODE_INV) ? cur_r.y[VALUE_WIDTH-1] : cur_r.x[VALUE_WIDTH-1]),
                 ((mode_r == MODE_INV) ? cur_r.y : cur_r.x)}
              - {s_prev[VALUE_WIDTH-1], s_prev};
    d_other   = {t_cur[VALUE_WIDTH-1], t_cur} - {t_prev[VALUE_WIDTH-1], t_prev};
    d_off     = {query_r[VALUE_WIDTH-1], query_r} - {s_prev[VALUE_WIDTH-1], s_prev};
    mag_this  = d_this[VALUE_WIDTH]  ? mag_t'(-d_this)  : mag_t'(d_this);
    mag_other = d_other[VALUE_WIDTH] ? mag_t'(-d_other) : mag_t'(d_other);
    mag_off   = d_off[VALUE_WIDTH]   ? mag_t'(-d_off)   : mag_t'(d_off);
    ans_wide  = neg_r ? ({{2{t_prev[VALUE_WIDTH-1]}}, t_prev} - {1'b0, md_quo})
                      : ({{2{t_prev[VALUE_WIDTH-1]}}, t_prev} + {1'b0, md_quo});
  end

  tint_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_PREP),
    .op_a     (mag_other),
    .op_b     (mag_off),
    .op_c     (mag_this),
    .done     (md_done),
    .quotient (md_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == 1'b0) begin
        point_count_r <= pwdata[CNT_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r       <= in_mode;
            query_r      <= in_query;
            last_r       <= count_less[IDX_W-1:0];
            res_answer_r <= '0;
            if ((in_mode == MODE_FWD || in_mode == MODE_INV) && count_eff < CNT_W'(2)) begin
              res_status_r <= ST_FEW;
              state_r      <= S_DONE;
            end else if (in_mode == MODE_FWD || in_mode == MODE_INV) begin
              res_status_r <= ST_OK;
              state_r      <= S_FIRST;
            end else begin
              res_status_r <= ST_OK;
              state_r      <= S_DONE;
            end
          end
        end
        S_FIRST: begin
          prev_r  <= rd_data_r;
          idx_r   <= IDX_W'(1);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (seg_hit && seg_flat) begin
            res_status_r <= ST_ZERO_SEG;
            state_r      <= S_DONE;
          end else if (seg_hit) begin
            cur_r   <= rd_data_r;
            state_r <= S_PREP;
          end else if (idx_r == last_r) begin
            res_status_r <= ST_RANGE;
            state_r      <= S_DONE;
          end else begin
            prev_r <= rd_data_r;
            idx_r  <= idx_r + 1'b1;
          end
        end
        S_PREP: begin
          neg_r   <= d_other[VALUE_WIDTH] ^ d_off[VALUE_WIDTH] ^ d_this[VALUE_WIDTH];
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (md_done) begin
            res_answer_r <= ans_wide[VALUE_WIDTH-1:0];
            res_status_r <= ST_OK;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_answer_r <= res_answer_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign out_status = out_status_r;

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_CALC)
    else $error("Divider finished outside the calculation state.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r <= last_r && idx_r != '0)
    else $error("Segment search ran past the last point in use.");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_WRITE |=> state_r == S_DONE)
    else $error("Write transaction did not complete directly.");

endmodule

[sv/tint_muldiv.sv]
// Serial unsigned multiply-then-divide unit: floor(a * b / c), one bit per cycle.
// Depends on tint_pkg. Requires b <= c and c != 0, so the quotient fits MAG_W bits.
module tint_muldiv import tint_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  mag_t op_a,
  input  mag_t op_b,
  input  mag_t op_c,
  output logic done,
  output mag_t quotient
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_t;

  ustate_t           state_r;
  logic [STEP_W-1:0] step_r;
  mag_t              a_r;
  mag_t              c_r;
  mag_t              hi_r;
  mag_t              lo_r;
  logic              done_r;

  logic [MAG_W:0] mul_sum;
  logic [MAG_W:0] trial;
  logic [MAG_W:0] trial_sub;
  logic           trial_ge;

  always_comb begin
    mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);
    trial     = {hi_r, lo_r[MAG_W-1]};
    trial_ge  = trial >= {1'b0, c_r};
    trial_sub = trial - {1'b0, c_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            a_r     <= op_a;
            c_r     <= op_c;
            hi_r    <= '0;
            lo_r    <= op_b;
            step_r  <= '0;
            state_r <= U_MUL;
          end
        end
        U_MUL: begin
          hi_r <= mul_sum[MAG_W:1];
          lo_r <= {mul_sum[0], lo_r[MAG_W-1:1]};
          if (step_r == STEP_W'(MAG_W - 1)) begin
            step_r  <= '0;
            state_r <= U_DIV;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        U_DIV: begin
          hi_r <= trial_ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
          lo_r <= {lo_r[MAG_W-2:0], trial_ge};
          if (step_r == STEP_W'(MAG_W - 1)) begin
            step_r  <= '0;
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = lo_r;

endmodule
